// ===== src/psd_pkg.sv =====
// Shared constants and types for the point-to-segment distance core.
package psd_pkg;

   typedef enum logic [1:0] {
      CSR_START_X = 2'd0,
      CSR_START_Y = 2'd1,
      CSR_END_X   = 2'd2,
      CSR_END_Y   = 2'd3
   } csr_index_type;

   localparam int CSR_INDEX_BITS = 2;

   // integer bits of the projection parameter t, sign included
   localparam int T_INT_BITS = 16;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = 2;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== src/psd_front.sv =====
// Front end: takes requests, forms differences and flags the degenerate line.
module psd_front #(
   parameter int C = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [C-1:0]          req_point_x,
   input  logic signed [C-1:0]          req_point_y,
   input  logic                         req_clamp_to_segment,
   input  logic signed [C-1:0]          start_x,
   input  logic signed [C-1:0]          start_y,
   input  logic signed [C-1:0]          end_x,
   input  logic signed [C-1:0]          end_y,
   input  psd_pkg::queue_status_type    q_status,
   output logic                         q_push,
   output logic [8*C+5:0]               q_data
);

   localparam int DW = C + 1;

   typedef struct packed {
      logic signed [DW-1:0] ux;
      logic signed [DW-1:0] uy;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic signed [C-1:0]  sx;
      logic signed [C-1:0]  sy;
      logic signed [C-1:0]  qx;
      logic signed [C-1:0]  qy;
      logic                 clamp;
      logic                 degen;
   } entry_type;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      accept;

   always_comb begin
      req_stall = valid_ff && q_status.full;
      accept    = req_valid && !req_stall;
      q_push    = valid_ff && !q_status.full;
      valid_in  = accept || (valid_ff && !q_push);
      q_data    = entry_ff;

      entry_in.ux    = DW'(req_point_x) - DW'(start_x);
      entry_in.uy    = DW'(req_point_y) - DW'(start_y);
      entry_in.dx    = DW'(end_x) - DW'(start_x);
      entry_in.dy    = DW'(end_y) - DW'(start_y);
      entry_in.sx    = start_x;
      entry_in.sy    = start_y;
      entry_in.qx    = req_point_x;
      entry_in.qy    = req_point_y;
      entry_in.clamp = req_clamp_to_segment;
      entry_in.degen = (start_x == end_x) && (start_y == end_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ===== src/psd_queue.sv =====
// Short request queue between the front end and the arithmetic back end.
module psd_queue #(
   parameter int W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [W-1:0]              push_data,
   input  logic                      pop,
   output logic [W-1:0]              pop_data,
   output psd_pkg::queue_status_type status
);

   localparam int PB = psd_pkg::QUEUE_PTR_BITS;

   logic [W-1:0]  mem [0:psd_pkg::QUEUE_DEPTH-1];
   logic [PB-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PB:0]   count_ff, count_in;

   always_comb begin
      status.full  = (count_ff == (PB+1)'(psd_pkg::QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      pop_data     = mem[rd_ptr_ff];
      wr_ptr_in    = push ? wr_ptr_ff + PB'(1) : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + PB'(1) : rd_ptr_ff;
      count_in     = count_ff + (PB+1)'(push) - (PB+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full || pop)
      else $error("queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PB+1)'(psd_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

// ===== src/psd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module psd_div #(
   parameter int NW  = 51,
   parameter int DVW = 34,
   parameter int QW  = 32,
   parameter int SBW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [NW-1:0]   num,
   input  logic [DVW-1:0]  den,
   input  logic [SBW-1:0]  sb_in,
   output logic            out_valid,
   output logic [QW-1:0]   quo,
   output logic            ovf,
   output logic [SBW-1:0]  sb_out
);

   localparam int EW = NW + QW + DVW;

   logic            valid_ff [0:QW];
   logic [NW-1:0]   rem_ff   [0:QW];
   logic [DVW-1:0]  den_ff   [0:QW];
   logic [QW-1:0]   quo_ff   [0:QW];
   logic            ovf_ff   [0:QW];
   logic [SBW-1:0]  sb_ff    [0:QW];
   logic            ovf_in;

   // quotient does not fit when num >= den * 2^QW
   assign ovf_in = (EW'(num) >= (EW'(den) << QW));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= ovf_in;
         sb_ff[0]  <= sb_in;
      end
   end

   for (genvar s = 0; s < QW; s++) begin : g_stage
      localparam int K = QW - 1 - s;
      logic [EW-1:0] trial;
      logic          take;
      logic [NW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      always_comb begin
         trial  = EW'(den_ff[s]) << K;
         take   = (EW'(rem_ff[s]) >= trial);
         rem_in = take ? rem_ff[s] - NW'(trial) : rem_ff[s];
         quo_in = quo_ff[s] | (QW'(take) << K);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (en) begin
            valid_ff[s+1] <= valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= rem_in;
            den_ff[s+1] <= den_ff[s];
            quo_ff[s+1] <= quo_in;
            ovf_ff[s+1] <= ovf_ff[s];
            sb_ff[s+1]  <= sb_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[QW];
   assign quo       = quo_ff[QW];
   assign ovf       = ovf_ff[QW];
   assign sb_out    = sb_ff[QW];

endmodule

// ===== src/psd_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage.
module psd_sqrt #(
   parameter int RW  = 35,
   parameter int SBW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [2*RW-1:0] radicand,
   input  logic [SBW-1:0]  sb_in,
   output logic            out_valid,
   output logic [RW-1:0]   root,
   output logic [RW:0]     rem,
   output logic [SBW-1:0]  sb_out
);

   localparam int VW = 2 * RW + 1;

   logic            valid_ff [0:RW];
   logic [VW-1:0]   num_ff   [0:RW];
   logic [VW-1:0]   res_ff   [0:RW];
   logic [SBW-1:0]  sb_ff    [0:RW];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff[0] <= VW'(radicand);
         res_ff[0] <= '0;
         sb_ff[0]  <= sb_in;
      end
   end

   for (genvar s = 0; s < RW; s++) begin : g_stage
      localparam int K = RW - 1 - s;
      logic [VW-1:0] trial;
      logic          take;
      logic [VW-1:0] num_in;
      logic [VW-1:0] res_in;

      always_comb begin
         trial  = res_ff[s] + (VW'(1) << (2 * K));
         take   = (num_ff[s] >= trial);
         num_in = take ? num_ff[s] - trial : num_ff[s];
         res_in = take ? (res_ff[s] >> 1) + (VW'(1) << (2 * K)) : (res_ff[s] >> 1);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (en) begin
            valid_ff[s+1] <= valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[s+1] <= num_in;
            res_ff[s+1] <= res_in;
            sb_ff[s+1]  <= sb_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[RW];
   assign root      = res_ff[RW][RW-1:0];
   assign rem       = num_ff[RW][RW:0];
   assign sb_out    = sb_ff[RW];

endmodule

// ===== src/psd_back.sv =====
// Back end: projection, divide, closest point, distance and saturation.
module psd_back #(
   parameter int C = 16,
   parameter int F = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [8*C+5:0]            q_data,
   input  psd_pkg::queue_status_type q_status,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [C-1:0]       rsp_nearest_x,
   output logic signed [C-1:0]       rsp_nearest_y,
   output logic [C:0]                rsp_distance,
   output logic                      rsp_degenerate
);

   localparam int DW  = C + 1;
   localparam int PW  = 2 * C + 2;
   localparam int NW  = PW + F + 1;
   localparam int TW  = psd_pkg::T_INT_BITS + F;
   localparam int OW  = DW + TW;
   localparam int FW  = OW - F;
   localparam int NXW = C + 18;
   localparam int EXW = C + 19;
   localparam int MW  = EXW - 1;
   localparam int SQW = 2 * MW + 1;
   localparam int RW  = MW + 1;

   typedef struct packed {
      logic signed [DW-1:0] ux;
      logic signed [DW-1:0] uy;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic signed [C-1:0]  sx;
      logic signed [C-1:0]  sy;
      logic signed [C-1:0]  qx;
      logic signed [C-1:0]  qy;
      logic                 clamp;
      logic                 degen;
   } entry_type;

   localparam int EW = $bits(entry_type);
   localparam int XW = 2 * NXW + 1;

   localparam logic [TW-1:0]         T_MAX = TW'(1) << (TW - 1);
   localparam logic signed [TW-1:0]  T_ONE = TW'(1) << F;
   localparam logic signed [NXW-1:0] NX_HI = (NXW'(1) << (C - 1)) - NXW'(1);
   localparam logic signed [NXW-1:0] NX_LO = -NX_HI - NXW'(1);
   localparam logic [RW:0]           D_MAX = (RW+1)'({(C+1){1'b1}});

   logic en;
   entry_type ent;

   // stage A: products
   logic va_ff;
   entry_type ea_ff;
   logic signed [PW-1:0] pxx_ff, pyy_ff, pux_ff, puy_ff;
   logic signed [PW-1:0] pxx_in, pyy_in, pux_in, puy_in;
   // stage B: sums
   logic vb_ff;
   entry_type eb_ff;
   logic [PW-1:0] l2_ff, l2_in;
   logic signed [PW:0] dot_ff, dot_in;
   // stage C: divider operands
   logic vc_ff;
   entry_type ec_ff;
   logic [PW-1:0] dotmag;
   logic [NW-1:0] num_ff, num_in;
   logic [PW-1:0] den_ff;
   logic neg_ff, neg_in;
   // divider outputs
   logic div_valid, div_ovf;
   logic [TW-1:0] div_quo;
   logic [EW:0] div_sb;
   entry_type et;
   logic tneg;
   logic [TW-1:0] tmag;
   // stage T
   logic vt_ff;
   entry_type et_ff;
   logic signed [TW-1:0] t_ff, t_in;
   // stage M
   logic vm_ff;
   entry_type em_ff;
   logic signed [OW-1:0] ox_ff, oy_ff, ox_in, oy_in;
   // stage R1
   logic vr1_ff;
   entry_type er1_ff;
   logic [OW-1:0] magx, magy;
   logic [FW-1:0] offx_ff, offy_ff, offx_in, offy_in;
   logic negx_ff, negy_ff;
   // stage R2
   logic vr2_ff;
   entry_type er2_ff;
   logic signed [NXW-1:0] nx2_ff, ny2_ff, nx2_in, ny2_in;
   // stage R3
   logic vr3_ff;
   logic signed [EXW-1:0] exd, eyd;
   logic [MW-1:0] mex_ff, mey_ff, mex_in, mey_in;
   logic [XW-1:0] x3_ff;
   // stage S1, S2
   logic vs1_ff, vs2_ff;
   logic [2*MW-1:0] sqx_ff, sqy_ff;
   logic [SQW-1:0] sum_ff, sum_in;
   logic [XW-1:0] x4_ff, x5_ff;
   // root
   logic sq_valid;
   logic [RW-1:0] sq_root;
   logic [RW:0] sq_rem, root_rnd;
   logic [XW-1:0] sq_sb;
   logic signed [NXW-1:0] fnx, fny;
   // output register
   logic rsp_valid_ff;
   logic signed [C-1:0] nearest_x_ff, nearest_y_ff, nearest_x_in, nearest_y_in;
   logic [C:0] distance_ff, distance_in;
   logic degenerate_ff;

   always_comb begin
      en    = !rsp_valid_ff || !rsp_stall;
      q_pop = en && !q_status.empty;
      ent   = entry_type'(q_data);

      pxx_in = PW'(ent.dx) * PW'(ent.dx);
      pyy_in = PW'(ent.dy) * PW'(ent.dy);
      pux_in = PW'(ent.ux) * PW'(ent.dx);
      puy_in = PW'(ent.uy) * PW'(ent.dy);

      l2_in  = pxx_ff + pyy_ff;
      dot_in = (PW+1)'(pux_ff) + (PW+1)'(puy_ff);

      neg_in = dot_ff[PW];
      dotmag = dot_ff[PW] ? PW'(-dot_ff) : PW'(dot_ff);
      num_in = (NW'(dotmag) << F) + NW'(l2_ff >> 1);

      // saturate t to its format, then clamp; zero length forces t = 0
      et   = entry_type'(div_sb[EW:1]);
      tneg = div_sb[0] && (div_ovf || (div_quo != '0));
      if (!tneg) begin
         tmag = (div_ovf || (div_quo >= T_MAX)) ? T_MAX - TW'(1) : div_quo;
      end else begin
         tmag = (div_ovf || (div_quo > T_MAX)) ? T_MAX : div_quo;
      end
      t_in = tneg ? -tmag : tmag;
      if (et.clamp) begin
         if (t_in < 0) begin
            t_in = '0;
         end else if (t_in > T_ONE) begin
            t_in = T_ONE;
         end
      end
      if (et.degen) begin
         t_in = '0;
      end

      ox_in = OW'(et_ff.dx) * OW'(t_ff);
      oy_in = OW'(et_ff.dy) * OW'(t_ff);

      magx    = ox_ff[OW-1] ? -ox_ff : ox_ff;
      magy    = oy_ff[OW-1] ? -oy_ff : oy_ff;
      offx_in = FW'(((OW+1)'(magx) + ((OW+1)'(1) << (F - 1))) >> F);
      offy_in = FW'(((OW+1)'(magy) + ((OW+1)'(1) << (F - 1))) >> F);

      nx2_in = NXW'(er1_ff.sx) + (negx_ff ? -NXW'(offx_ff) : NXW'(offx_ff));
      ny2_in = NXW'(er1_ff.sy) + (negy_ff ? -NXW'(offy_ff) : NXW'(offy_ff));

      exd    = EXW'(er2_ff.qx) - EXW'(nx2_ff);
      eyd    = EXW'(er2_ff.qy) - EXW'(ny2_ff);
      mex_in = exd[EXW-1] ? MW'(-exd) : MW'(exd);
      mey_in = eyd[EXW-1] ? MW'(-eyd) : MW'(eyd);

      sum_in = SQW'(sqx_ff) + SQW'(sqy_ff);

      // round to nearest: up when remainder exceeds the root
      root_rnd = (RW+1)'(sq_root) + (RW+1)'(sq_rem > (RW+1)'(sq_root));
      distance_in = (root_rnd > D_MAX) ? {(C+1){1'b1}} : root_rnd[C:0];
      fnx = sq_sb[XW-1:NXW+1];
      fny = sq_sb[NXW:1];
      nearest_x_in = (fnx > NX_HI) ? NX_HI[C-1:0] : (fnx < NX_LO) ? NX_LO[C-1:0] : fnx[C-1:0];
      nearest_y_in = (fny > NX_HI) ? NX_HI[C-1:0] : (fny < NX_LO) ? NX_LO[C-1:0] : fny[C-1:0];
   end

   psd_div #(.NW(NW), .DVW(PW), .QW(TW), .SBW(EW + 1)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vc_ff),
      .num       (num_ff),
      .den       (den_ff),
      .sb_in     ({ec_ff, neg_ff}),
      .out_valid (div_valid),
      .quo       (div_quo),
      .ovf       (div_ovf),
      .sb_out    (div_sb)
   );

   psd_sqrt #(.RW(RW), .SBW(XW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vs2_ff),
      .radicand  ((2*RW)'(sum_ff)),
      .sb_in     (x5_ff),
      .out_valid (sq_valid),
      .root      (sq_root),
      .rem       (sq_rem),
      .sb_out    (sq_sb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vt_ff        <= 1'b0;
         vm_ff        <= 1'b0;
         vr1_ff       <= 1'b0;
         vr2_ff       <= 1'b0;
         vr3_ff       <= 1'b0;
         vs1_ff       <= 1'b0;
         vs2_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         va_ff        <= q_pop;
         vb_ff        <= va_ff;
         vc_ff        <= vb_ff;
         vt_ff        <= div_valid;
         vm_ff        <= vt_ff;
         vr1_ff       <= vm_ff;
         vr2_ff       <= vr1_ff;
         vr3_ff       <= vr2_ff;
         vs1_ff       <= vr3_ff;
         vs2_ff       <= vs1_ff;
         rsp_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ea_ff  <= ent;
         pxx_ff <= pxx_in;
         pyy_ff <= pyy_in;
         pux_ff <= pux_in;
         puy_ff <= puy_in;

         eb_ff  <= ea_ff;
         l2_ff  <= l2_in;
         dot_ff <= dot_in;

         ec_ff  <= eb_ff;
         num_ff <= num_in;
         den_ff <= l2_ff;
         neg_ff <= neg_in;

         et_ff  <= et;
         t_ff   <= t_in;

         em_ff  <= et_ff;
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;

         er1_ff  <= em_ff;
         offx_ff <= offx_in;
         offy_ff <= offy_in;
         negx_ff <= ox_ff[OW-1];
         negy_ff <= oy_ff[OW-1];

         er2_ff <= er1_ff;
         nx2_ff <= nx2_in;
         ny2_ff <= ny2_in;

         mex_ff <= mex_in;
         mey_ff <= mey_in;
         x3_ff  <= {nx2_ff, ny2_ff, er2_ff.degen};

         sqx_ff <= (2*MW)'(mex_ff) * (2*MW)'(mex_ff);
         sqy_ff <= (2*MW)'(mey_ff) * (2*MW)'(mey_ff);
         x4_ff  <= x3_ff;

         sum_ff <= sum_in;
         x5_ff  <= x4_ff;

         nearest_x_ff  <= nearest_x_in;
         nearest_y_ff  <= nearest_y_in;
         distance_ff   <= distance_in;
         degenerate_ff <= sq_sb[0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_nearest_x  = nearest_x_ff;
   assign rsp_nearest_y  = nearest_y_ff;
   assign rsp_distance   = distance_ff;
   assign rsp_degenerate = degenerate_ff;

   a_pop_only_when_moving: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> en && !q_status.empty)
      else $error("request taken from queue while back end stalled");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vt_ff) && $stable(vs2_ff))
      else $error("pipeline moved while output stalled");

   a_degen_on_zero_line: assert property (@(posedge clock) disable iff (reset)
      vt_ff && et_ff.degen |-> t_ff == '0)
      else $error("zero-length line with non-zero projection");

endmodule

// ===== src/point_segment_closest_distance_core.sv =====
// Closest point on a line or segment to a query point, with the distance to it.
// The line's endpoints live in four write-only registers (start_x, start_y, end_x, end_y,
// indexes 0 to 3). Each request carries a query point and a clamp flag and yields one
// response with the saturated closest point, the rounded distance and a flag for a
// zero-length line. The block takes one request per clock and returns one response per
// clock while req_stall and rsp_stall stay low. The pipelined divider has PARAM_FRAC_BITS
// + 17 stages and the pipelined square root has COORD_BITS + 20 stages. A four-entry
// queue sits between the request front end and the arithmetic pipeline, so requests
// keep being taken while rsp_stall is held, until the queue and the front-end register are full.
module point_segment_closest_distance_core #(
   parameter int COORD_BITS      = 16,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_BITS-1:0]          req_point_x,
   input  logic signed [COORD_BITS-1:0]          req_point_y,
   input  logic                                  req_clamp_to_segment,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [COORD_BITS-1:0]          rsp_nearest_x,
   output logic signed [COORD_BITS-1:0]          rsp_nearest_y,
   output logic [COORD_BITS:0]                   rsp_distance,
   output logic                                  rsp_degenerate,
   input  logic                                  csr_we,
   input  logic [psd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [COORD_BITS-1:0]                 csr_wdata
);

   localparam int QEW = 8 * COORD_BITS + 6;

   logic signed [COORD_BITS-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic                         q_push, q_pop;
   logic [QEW-1:0]               q_wdata, q_rdata;
   psd_pkg::queue_status_type    q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         end_x_ff   <= '0;
         end_y_ff   <= '0;
      end else if (csr_we) begin
         unique case (psd_pkg::csr_index_type'(csr_index))
            psd_pkg::CSR_START_X: start_x_ff <= csr_wdata;
            psd_pkg::CSR_START_Y: start_y_ff <= csr_wdata;
            psd_pkg::CSR_END_X:   end_x_ff   <= csr_wdata;
            psd_pkg::CSR_END_Y:   end_y_ff   <= csr_wdata;
         endcase
      end
   end

   psd_front #(.C(COORD_BITS)) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_point_x          (req_point_x),
      .req_point_y          (req_point_y),
      .req_clamp_to_segment (req_clamp_to_segment),
      .start_x              (start_x_ff),
      .start_y              (start_y_ff),
      .end_x                (end_x_ff),
      .end_y                (end_y_ff),
      .q_status             (q_status),
      .q_push               (q_push),
      .q_data               (q_wdata)
   );

   psd_queue #(.W(QEW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .status    (q_status)
   );

   psd_back #(.C(COORD_BITS), .F(PARAM_FRAC_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_data         (q_rdata),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_nearest_x  (rsp_nearest_x),
      .rsp_nearest_y  (rsp_nearest_y),
      .rsp_distance   (rsp_distance),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the point-to-segment closest distance core.
`timescale 1ns / 1ps

module tb_top;

   localparam int CB = 16;
   localparam int FB = 16;
   localparam int SETTLE_CYCLES = 120;

   typedef struct {
      logic signed [CB-1:0] px;
      logic signed [CB-1:0] py;
      logic                 clamp;
   } query_type;

   typedef struct {
      logic signed [CB-1:0] nx;
      logic signed [CB-1:0] ny;
      logic [CB:0]          dist_q4;
      logic                 degen;
   } nearest_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CB-1:0] req_point_x = '0;
   logic signed [CB-1:0] req_point_y = '0;
   logic req_clamp_to_segment = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [CB-1:0] rsp_nearest_x;
   logic signed [CB-1:0] rsp_nearest_y;
   logic [CB:0] rsp_distance;
   logic rsp_degenerate;
   logic csr_we = 1'b0;
   logic [psd_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CB-1:0] csr_wdata = '0;

   point_segment_closest_distance_core #(.COORD_BITS(CB), .PARAM_FRAC_BITS(FB)) dut (.*);

   // line held by the testbench, mirrors the block's registers
   logic signed [CB-1:0] line_sx = '0, line_sy = '0, line_ex = '0, line_ey = '0;

   query_type   pending_queries[$];
   nearest_type expected_points[$];
   int       mismatches = 0;
   int       queries_sent = 0;
   int       points_checked = 0;
   int       degen_seen = 0;
   bit       no_gaps = 1'b0;
   int       req_gap = 0;
   int       rsp_hold = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic nearest_type project_point(query_type q);
      nearest_type res;
      longint sx, sy, dx, dy, qx, qy, nx, ny, dot, l2, quo, mag, t, ox, oy, offx, offy, ex, ey;
      logic [127:0] ax, ay, v, r, c;
      sx = longint'(line_sx);
      sy = longint'(line_sy);
      dx = longint'(line_ex) - sx;
      dy = longint'(line_ey) - sy;
      qx = longint'(q.px);
      qy = longint'(q.py);
      nx = sx;
      ny = sy;
      res.degen = (dx == 0 && dy == 0);
      if (!res.degen) begin
         l2 = dx * dx + dy * dy;
         dot = (qx - sx) * dx + (qy - sy) * dy;
         mag = dot < 0 ? -dot : dot;
         quo = ((mag <<< FB) + (l2 >>> 1)) / l2;
         // t saturates to its Q16.F range before any clamp
         if (dot < 0 && quo != 0)
            t = -((quo > (64'sd1 <<< (15 + FB))) ? (64'sd1 <<< (15 + FB)) : quo);
         else
            t = (quo >= (64'sd1 <<< (15 + FB))) ? (64'sd1 <<< (15 + FB)) - 1 : quo;
         if (q.clamp) begin
            if (t < 0) t = 0;
            if (t > (64'sd1 <<< FB)) t = 64'sd1 <<< FB;
         end
         ox = dx * t;
         oy = dy * t;
         offx = ((ox < 0 ? -ox : ox) + (64'sd1 <<< (FB - 1))) >>> FB;
         offy = ((oy < 0 ? -oy : oy) + (64'sd1 <<< (FB - 1))) >>> FB;
         nx = sx + (ox < 0 ? -offx : offx);
         ny = sy + (oy < 0 ? -offy : offy);
      end
      ex = qx - nx;
      ey = qy - ny;
      ax = 128'(ex < 0 ? -ex : ex);
      ay = 128'(ey < 0 ? -ey : ey);
      v = ax * ax + ay * ay;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (128'd1 << b);
         if (c * c <= v) r = c;
      end
      if (r * r + r < v) r = r + 128'd1;
      res.dist_q4 = (r > 128'd131071) ? 17'h1ffff : r[CB:0];
      res.nx = nx > 32767 ? 16'sh7fff : (nx < -32768 ? 16'sh8000 : nx[CB-1:0]);
      res.ny = ny > 32767 ? 16'sh7fff : (ny < -32768 ? 16'sh8000 : ny[CB-1:0]);
      return res;
   endfunction

   // request driver
   always @(posedge clock) begin
      logic      vld;
      query_type q;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         vld = req_valid;
         if (req_valid && !req_stall) begin
            q.px = req_point_x;
            q.py = req_point_y;
            q.clamp = req_clamp_to_segment;
            expected_points.push_back(project_point(q));
            queries_sent++;
            vld = 1'b0;
         end
         if (!vld) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_queries.size() > 0) begin
               q = pending_queries.pop_front();
               req_point_x <= q.px;
               req_point_y <= q.py;
               req_clamp_to_segment <= q.clamp;
               vld = 1'b1;
               req_gap = no_gaps ? 0 : $urandom_range(0, 13);
            end
         end
         req_valid <= vld;
      end
   end

   // response monitor and back-pressure
   always @(posedge clock) begin
      nearest_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response nx=%0d ny=%0d",
                                              rsp_nearest_x, rsp_nearest_y);
            end else begin
               e = expected_points.pop_front();
               points_checked++;
               if (e.degen) degen_seen++;
               if (rsp_nearest_x !== e.nx || rsp_nearest_y !== e.ny ||
                   rsp_distance !== e.dist_q4 || rsp_degenerate !== e.degen) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp x=%0d y=%0d d=%0d g=%0b got x=%0d y=%0d d=%0d g=%0b",
                              e.nx, e.ny, e.dist_q4, e.degen, rsp_nearest_x, rsp_nearest_y,
                              rsp_distance, rsp_degenerate);
               end
            end
            rsp_hold = no_gaps ? 0 : $urandom_range(0, 13);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_line(logic signed [CB-1:0] sx, sy, ex, ey);
      logic [CB-1:0] vals[4];
      psd_pkg::csr_index_type idx[4];
      vals = '{sx, sy, ex, ey};
      idx = '{psd_pkg::CSR_START_X, psd_pkg::CSR_START_Y, psd_pkg::CSR_END_X,
              psd_pkg::CSR_END_Y};
      for (int i = 0; i < 4; i++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      line_sx = sx;
      line_sy = sy;
      line_ex = ex;
      line_ey = ey;
   endtask

   task automatic queue_query(logic signed [CB-1:0] px, py, logic clamp);
      query_type q;
      q.px = px;
      q.py = py;
      q.clamp = clamp;
      pending_queries.push_back(q);
   endtask

   task automatic drain;
      while (pending_queries.size() != 0 || expected_points.size() != 0 || req_valid)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CB-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return CB'($urandom_range(0, 255) - 128);
         default: return CB'($urandom);
      endcase
   endfunction

   initial begin
      logic signed [CB-1:0] a, b;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // registers reset to a zero-length line
      queue_query(16'sh7fff, 16'sh8000, 1'b1);
      queue_query(16'sh8000, 16'sh7fff, 1'b0);
      queue_query(16'sd0, 16'sd0, 1'b0);
      drain();
      // longest diagonal, corner points
      write_line(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
      queue_query(16'sh8000, 16'sh7fff, 1'b0);
      queue_query(16'sh7fff, 16'sh8000, 1'b1);
      queue_query(16'sh7fff, 16'sh7fff, 1'b0);
      queue_query(16'sh8000, 16'sh8000, 1'b1);
      queue_query(16'sh7fff, 16'sh8000, 1'b0);
      drain();
      // short line: before, on and past the segment, clamped and not
      write_line(16'sd16, 16'sd16, 16'sd48, 16'sd16);
      queue_query(-16'sd400, 16'sd100, 1'b0);
      queue_query(-16'sd400, 16'sd100, 1'b1);
      queue_query(16'sd32, 16'sd80, 1'b1);
      queue_query(16'sh7fff, 16'sh8000, 1'b0);
      queue_query(16'sh7fff, 16'sh8000, 1'b1);
      queue_query(16'sd16, 16'sd16, 1'b0);
      drain();
      // unit-length line: t reaches its lower bound, closest points reach the coordinate limits
      write_line(16'sd0, 16'sd0, 16'sd1, 16'sd0);
      queue_query(16'sh7fff, 16'sd0, 1'b0);
      queue_query(16'sh8000, 16'sh7fff, 1'b0);
      queue_query(16'sh8000, 16'sd0, 1'b1);
      drain();
      write_line(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
      queue_query(16'sh8000, 16'sh8000, 1'b0);
      queue_query(16'sd0, 16'sd0, 1'b1);
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         no_gaps = (ph % 4 == 3);
         case (ph % 4)
            0: write_line(CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom));
            1: write_line(pick_coord(), pick_coord(), pick_coord(), pick_coord());
            2: begin
               a = CB'($urandom);
               b = CB'($urandom);
               if ($urandom_range(0, 1))
                  write_line(a, b, a, b);
               else
                  write_line(a, b, CB'(a + $urandom_range(0, 3) - 1),
                             CB'(b + $urandom_range(0, 2) - 1));
            end
            default: write_line(CB'($urandom_range(0, 1023) - 512),
                                CB'($urandom_range(0, 1023) - 512),
                                CB'($urandom_range(0, 1023) - 512),
                                CB'($urandom_range(0, 1023) - 512));
         endcase
         for (int i = 0; i < 125; i++) begin
            if ($urandom_range(0, 2) == 0)
               queue_query(CB'(line_sx + $urandom_range(0, 2047) - 1024),
                           CB'(line_sy + $urandom_range(0, 2047) - 1024),
                           1'($urandom_range(0, 1)));
            else
               queue_query(pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
         end
         drain();
      end

      $display("%0d queries sent, %0d responses checked (%0d on zero-length lines)",
               queries_sent, points_checked, degen_seen);
      if (mismatches == 0)
         $display("PASS point_segment_closest_distance_core");
      else
         $display("FAIL point_segment_closest_distance_core");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL point_segment_closest_distance_core");
      $finish;
   end

endmodule
